### design/rad_pkg.sv
// Package for the resource allocation DP block: word types, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package rad_pkg;

    // Field widths fixed by the interface
    localparam int unsigned ProfitW = 16;
    localparam int unsigned TotalW  = 32;
    localparam int unsigned CountW  = 5;
    localparam logic [CountW-1:0] NumDevReset = 5'd10;

    // Input word: one factory profit for the next device count
    typedef struct packed {
        logic [ProfitW-1:0] profit;
        logic               new_problem;
    } in_word_t;

    // Result word: best total and winning share for one device count
    typedef struct packed {
        logic [CountW-1:0]  device_count;
        logic [TotalW-1:0]  best_total;
        logic [CountW-1:0]  chosen_share;
        logic               row_done;
    } out_word_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE,
        ST_COPY,
        ST_COPY_END
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the input word
        logic scan;     // issue one candidate read
        logic done;     // present result, store current total
        logic copy;     // issue one row copy read
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_end; // last candidate being read
        logic copy_end; // last row entry being read
        logic last;     // this word closes its row
    } status_t;

endpackage

### design/rad_ctrl.sv
// Controller state machine for the resource allocation DP block.
// Depends on rad_pkg for state, command and status types.
module rad_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rad_pkg::status_t status,
    output rad_pkg::cmd_t    cmd,
    output logic             busy
);

    rad_pkg::state_t state_reg;
    rad_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rad_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rad_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rad_pkg::ST_SCAN;
                end
            end
            rad_pkg::ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = rad_pkg::ST_DRAIN;
                end
            end
            rad_pkg::ST_DRAIN:
            begin
                state_next = rad_pkg::ST_DONE;
            end
            rad_pkg::ST_DONE:
            begin
                state_next = status.last ? rad_pkg::ST_COPY : rad_pkg::ST_IDLE;
            end
            rad_pkg::ST_COPY:
            begin
                if (status.copy_end)
                begin
                    state_next = rad_pkg::ST_COPY_END;
                end
            end
            rad_pkg::ST_COPY_END:
            begin
                state_next = rad_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rad_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            rad_pkg::ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            rad_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            rad_pkg::ST_DONE:
            begin
                cmd.done = 1'b1;
            end
            rad_pkg::ST_COPY:
            begin
                cmd.copy = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### design/rad_datapath.sv
// Datapath for the resource allocation DP block: row stores, candidate
// scan with one saturating adder and comparator, row copy sweep.
// Depends on rad_pkg for word, command and status types.
module rad_datapath #(
    parameter int unsigned MAX_DEVICES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rad_pkg::cmd_t                 cmd,
    input  rad_pkg::in_word_t             item,
    input  logic                          cfg_we,
    input  logic [rad_pkg::CountW-1:0]    cfg_data,
    output rad_pkg::status_t              status,
    output rad_pkg::out_word_t            result
);

    localparam int unsigned IW = $clog2(MAX_DEVICES + 1);
    localparam int unsigned LW = (IW > rad_pkg::CountW) ? IW : rad_pkg::CountW;
    localparam logic [LW-1:0] MaxExt = LW'(MAX_DEVICES);
    localparam logic [IW-1:0] IdxOne = IW'(1);

    // Row stores
    logic [rad_pkg::ProfitW-1:0] prof_mem [0:MAX_DEVICES];
    logic [rad_pkg::TotalW-1:0]  curb_mem [0:MAX_DEVICES];
    logic [rad_pkg::TotalW-1:0]  prev_mem [0:MAX_DEVICES];

    // Control registers
    logic [rad_pkg::CountW-1:0] num_dev_reg;
    logic [IW-1:0]              idx_reg;
    logic [IW-1:0]              idx_next;
    logic [IW-1:0]              i_reg;
    logic                       last_reg;
    logic [IW-1:0]              k_reg;
    logic [IW-1:0]              c_reg;
    logic                       rd_v_reg;
    logic                       rd_kz_reg;
    logic [IW-1:0]              rd_k_reg;
    logic                       wr_pend_reg;
    logic [MAX_DEVICES:0]       prev_valid_reg;

    // Payload registers
    logic [rad_pkg::ProfitW-1:0] prof_rd_reg;
    logic [rad_pkg::TotalW-1:0]  prev_rd_reg;
    logic                        prev_vrd_reg;
    logic [rad_pkg::TotalW-1:0]  best_reg;
    logic [IW-1:0]               share_reg;
    logic [rad_pkg::TotalW-1:0]  cb_rd_reg;
    logic [IW-1:0]               wr_addr_reg;

    // Combinational values
    logic [IW-1:0]              i_sel;
    logic [IW-1:0]              i_raw;
    logic [LW-1:0]              num_ext;
    logic [LW-1:0]              len_ext;
    logic                       last_sel;
    logic [IW-1:0]              prev_addr;
    logic [rad_pkg::ProfitW-1:0] prof_eff;
    logic [rad_pkg::TotalW-1:0]  prev_eff;
    logic [rad_pkg::TotalW:0]    sum_wide;
    logic [rad_pkg::TotalW-1:0]  cand;
    logic                        take;
    logic [LW-1:0]               i_out_ext;
    logic [LW-1:0]               share_out_ext;

    // Row length and index of the incoming word
    always_comb
    begin
        num_ext = LW'(num_dev_reg);
        if (num_dev_reg == '0)
        begin
            len_ext = LW'(1);
        end
        else if (num_ext > MaxExt)
        begin
            len_ext = MaxExt;
        end
        else
        begin
            len_ext = num_ext;
        end
        i_raw = item.new_problem ? IdxOne : idx_reg;
        if ((i_raw == '0) || (LW'(i_raw) > MaxExt))
        begin
            i_sel = IdxOne;
        end
        else
        begin
            i_sel = i_raw;
        end
        last_sel = (LW'(i_sel) >= len_ext);
        idx_next = last_sel ? IdxOne : (i_sel + IdxOne);
    end

    // Candidate: profit[k] + prev_best[i-k], saturating
    assign prev_addr = i_reg - k_reg;
    assign prof_eff  = rd_kz_reg ? '0 : prof_rd_reg;
    assign prev_eff  = prev_vrd_reg ? prev_rd_reg : '0;
    assign sum_wide  = {1'b0, prev_eff} + (rad_pkg::TotalW + 1)'(prof_eff);
    assign cand      = sum_wide[rad_pkg::TotalW] ? '1 : sum_wide[rad_pkg::TotalW-1:0];
    assign take      = rd_v_reg && (cand > best_reg);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dev_reg <= rad_pkg::NumDevReset;
        end
        else if (cfg_we)
        begin
            num_dev_reg <= cfg_data;
        end
    end

    // Control: index, counters, pipeline flags, previous-row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= IdxOne;
            i_reg          <= IdxOne;
            last_reg       <= 1'b0;
            k_reg          <= '0;
            c_reg          <= '0;
            rd_v_reg       <= 1'b0;
            rd_kz_reg      <= 1'b0;
            rd_k_reg       <= '0;
            wr_pend_reg    <= 1'b0;
            prev_valid_reg <= '0;
        end
        else
        begin
            rd_v_reg    <= cmd.scan;
            rd_k_reg    <= k_reg;
            rd_kz_reg   <= (k_reg == '0);
            wr_pend_reg <= cmd.copy;
            if (cmd.accept)
            begin
                idx_reg  <= idx_next;
                i_reg    <= i_sel;
                last_reg <= last_sel;
                k_reg    <= '0;
                if (item.new_problem)
                begin
                    prev_valid_reg <= '0;
                end
            end
            if (cmd.scan)
            begin
                k_reg <= k_reg + IdxOne;
            end
            if (cmd.done)
            begin
                c_reg <= IdxOne;
            end
            if (cmd.copy)
            begin
                c_reg <= c_reg + IdxOne;
            end
            if (wr_pend_reg)
            begin
                prev_valid_reg[wr_addr_reg] <= 1'b1;
            end
        end
    end

    // Best candidate so far
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            best_reg  <= '0;
            share_reg <= '0;
        end
        else if (take)
        begin
            best_reg  <= cand;
            share_reg <= rd_k_reg;
        end
    end

    // Current profits: written on accept, read during the scan
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            prof_mem[i_sel] <= item.profit;
        end
        prof_rd_reg <= prof_mem[k_reg];
    end

    // Current totals: written at result time, read during the copy
    always_ff @(posedge clk)
    begin
        if (cmd.done)
        begin
            curb_mem[i_reg] <= best_reg;
        end
        cb_rd_reg   <= curb_mem[c_reg];
        wr_addr_reg <= c_reg;
    end

    // Previous totals: written by the copy, read during the scan
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            prev_mem[wr_addr_reg] <= cb_rd_reg;
        end
        prev_rd_reg  <= prev_mem[prev_addr];
        prev_vrd_reg <= prev_valid_reg[prev_addr];
    end

    // Status to the controller
    assign status.scan_end = (k_reg == i_reg);
    assign status.copy_end = (c_reg == i_reg);
    assign status.last     = last_reg;

    // Result word
    assign i_out_ext           = LW'(i_reg);
    assign share_out_ext       = LW'(share_reg);
    assign result.device_count = i_out_ext[rad_pkg::CountW-1:0];
    assign result.best_total   = best_reg;
    assign result.chosen_share = share_out_ext[rad_pkg::CountW-1:0];
    assign result.row_done     = last_reg;

endmodule

### design/resource_allocation_dp_core.sv
// Resource allocation DP core. An item for device count i is taken when start is
// high and busy low; its result strobe follows the candidate scan and a drain state.
// Each item runs a candidate scan (one read per cycle through the row stores), and
// the last item of a row adds a row copy sweep.
// The receiver cannot stall. Reset (rst_n, asynchronous, active low) clears the
// previous-row totals, sets the row index to one and the row length to ten.
module resource_allocation_dp_core #(
    parameter int unsigned MAX_DEVICES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rad_pkg::in_word_t          item,
    output logic                       result_valid,
    output rad_pkg::out_word_t         result,
    input  logic                       cfg_we,
    input  logic [rad_pkg::CountW-1:0] cfg_data
);

    rad_pkg::cmd_t    cmd;
    rad_pkg::status_t status;

    // Controller
    rad_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath
    rad_datapath #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .status   (status),
        .result   (result)
    );

    // Result strobe
    assign result_valid = cmd.done;

endmodule

### design/rad_checker.sv
// Port-level checks for the resource allocation DP core, bound to the top level.
// Depends on rad_pkg for the word types.
module rad_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               result_valid,
    input rad_pkg::out_word_t result
);

    // A result word lasts a single cycle
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    // An accepted word makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepting a word");

    // Results only come while a word is in progress
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe while idle");

    // Mid-row results free the block in the next cycle
    a_mid_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.row_done) |=> !busy)
        else $error("block still busy after a mid-row result");

    // The share never exceeds the device count, which is never zero
    a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.device_count != '0) &&
                          (result.chosen_share <= result.device_count)))
        else $error("chosen share out of range");

endmodule

bind resource_allocation_dp_core rad_checker u_rad_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

### sim/tb_top.sv
// Self-checking testbench for resource_allocation_dp_core: a directed table, then
// random factory rows under several row lengths, checked against an in-bench DP model.
// Depends on rad_pkg and the core only.
module tb_top;

    localparam int MaxDev   = 16;
    localparam int NumWords = 1400;

    typedef enum logic {
        ROW_WORD,
        SET_LEN
    } step_kind_t;

    // One row of the directed table: a length write or a word, with an optional
    // hand-written result
    typedef struct packed {
        step_kind_t         kind;
        logic [4:0]         len;
        rad_pkg::in_word_t  word;
        logic               typed;
        rad_pkg::out_word_t res;
    } step_t;

    localparam int DirSteps = 22;
    localparam step_t DirPlan [DirSteps] = '{
        '{SET_LEN,  5'd3,  '{16'd0, 1'b0},     1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        // nothing above zero: total and share both stay zero
        '{ROW_WORD, 5'd0,  '{16'd0, 1'b0},     1'b1, '{5'd1, 32'd0, 5'd0, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd0, 1'b0},     1'b1, '{5'd2, 32'd0, 5'd0, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd0, 1'b0},     1'b1, '{5'd3, 32'd0, 5'd0, 1'b1}},
        // full-scale profits, equal sums at i = 3 keep the smaller share
        '{ROW_WORD, 5'd0,  '{16'hFFFF, 1'b0},  1'b1, '{5'd1, 32'd65535, 5'd1, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd0, 1'b0},     1'b1, '{5'd2, 32'd65535, 5'd1, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'hFFFF, 1'b0},  1'b1, '{5'd3, 32'd65535, 5'd1, 1'b1}},
        // new problem clears the previous totals
        '{ROW_WORD, 5'd0,  '{16'd7, 1'b1},     1'b1, '{5'd1, 32'd7, 5'd1, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd7, 1'b0},     1'b1, '{5'd2, 32'd7, 5'd1, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd7, 1'b0},     1'b1, '{5'd3, 32'd7, 5'd1, 1'b1}},
        // length of zero acts as one
        '{SET_LEN,  5'd0,  '{16'd0, 1'b0},     1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'hFFFF, 1'b0},  1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd3, 1'b0},     1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        // length above the maximum acts as the maximum, then shrinks mid-row
        '{SET_LEN,  5'd17, '{16'd0, 1'b0},     1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd100, 1'b1},   1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd200, 1'b0},   1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd300, 1'b0},   1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd400, 1'b0},   1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd500, 1'b0},   1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        '{SET_LEN,  5'd4,  '{16'd0, 1'b0},     1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd600, 1'b0},   1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}},
        '{ROW_WORD, 5'd0,  '{16'd5, 1'b0},     1'b0, '{5'd0, 32'd0, 5'd0, 1'b0}}
    };

    // Row lengths swept first in the random part, extremes included
    localparam logic [4:0] LenSweep [10] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2,
                                             5'd17, 5'd5, 5'd8, 5'd3, 5'd10};

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    rad_pkg::in_word_t  item;
    logic               result_valid;
    rad_pkg::out_word_t result;
    logic               cfg_we;
    logic [rad_pkg::CountW-1:0] cfg_data;

    // DP model state
    logic [rad_pkg::TotalW-1:0]  prior_totals [0:MaxDev];
    logic [rad_pkg::TotalW-1:0]  row_totals   [0:MaxDev];
    logic [rad_pkg::ProfitW-1:0] row_profits  [0:MaxDev];
    logic [rad_pkg::CountW-1:0]  next_count;
    logic [rad_pkg::CountW-1:0]  row_len_reg;

    rad_pkg::out_word_t awaited_results [$];
    int                 mismatches;
    int                 words_sent;

    resource_allocation_dp_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Best split for the next device count; updates the row state.
    // Totals cannot reach saturation: at most 16 factories hold devices.
    function automatic rad_pkg::out_word_t best_split(input rad_pkg::in_word_t w);
        logic [rad_pkg::TotalW:0]   sum;
        logic [rad_pkg::TotalW-1:0] cand;
        logic [rad_pkg::TotalW-1:0] best;
        logic [rad_pkg::CountW-1:0] idx;
        logic [rad_pkg::CountW-1:0] share;
        logic [rad_pkg::CountW-1:0] len;
        logic                       last;
        rad_pkg::out_word_t         res;
        len = (row_len_reg == 0) ? 5'd1 :
              (row_len_reg > MaxDev) ? 5'(MaxDev) : row_len_reg;
        if (w.new_problem)
        begin
            for (int k = 0; k <= MaxDev; k++)
                prior_totals[k] = '0;
            next_count = 5'd1;
        end
        idx = next_count;
        if (idx < 1 || idx > MaxDev)
            idx = 5'd1;
        row_profits[0]   = '0;
        row_profits[idx] = w.profit;
        best  = '0;
        share = '0;
        for (int k = 0; k <= idx; k++)
        begin
            sum  = {17'd0, row_profits[k]} + {1'b0, prior_totals[idx - k]};
            cand = sum[rad_pkg::TotalW] ? '1 : sum[rad_pkg::TotalW-1:0];
            if (cand > best)
            begin
                best  = cand;
                share = k[rad_pkg::CountW-1:0];
            end
        end
        row_totals[idx] = best;
        last = (idx >= len);
        if (last)
        begin
            for (int k = 1; k <= idx; k++)
                prior_totals[k] = row_totals[k];
            prior_totals[0] = '0;
            next_count      = 5'd1;
        end
        else
            next_count = idx + 5'd1;
        res.device_count = idx;
        res.best_total   = best;
        res.chosen_share = share;
        res.row_done     = last;
        return res;
    endfunction

    // Idle gap length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Profit mix: zeros, full scale, small values for ties, anything
    function automatic logic [rad_pkg::ProfitW-1:0] pick_profit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 45)
            return 16'($urandom_range(0, 15));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Offer one word; start stays high on return
    task automatic push_word(input rad_pkg::in_word_t w, input logic typed,
                             input rad_pkg::out_word_t typed_res);
        rad_pkg::out_word_t predicted;
        @(negedge clk);
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = best_split(w);
        awaited_results.push_back(typed ? typed_res : predicted);
        words_sent++;
    endtask

    task automatic hold_off(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    // Let the core drain, including a row copy sweep, then write the row length
    task automatic set_row_length(input logic [rad_pkg::CountW-1:0] len);
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (MaxDev + 8)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(negedge clk);
        cfg_we <= 1'b0;
        row_len_reg = len;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        rad_pkg::out_word_t want;
        if (rst_n && result_valid)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result word: count %0d total %0d",
                       result.device_count, result.best_total);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.device_count !== want.device_count)
                begin
                    $error("device_count: expected %0d, got %0d",
                           want.device_count, result.device_count);
                    mismatches++;
                end
                if (result.best_total !== want.best_total)
                begin
                    $error("best_total: expected %0d, got %0d",
                           want.best_total, result.best_total);
                    mismatches++;
                end
                if (result.chosen_share !== want.chosen_share)
                begin
                    $error("chosen_share: expected %0d, got %0d",
                           want.chosen_share, result.chosen_share);
                    mismatches++;
                end
                if (result.row_done !== want.row_done)
                begin
                    $error("row_done: expected %0d, got %0d",
                           want.row_done, result.row_done);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        rad_pkg::in_word_t  w;
        rad_pkg::out_word_t none;
        int                 phase;
        int                 phase_words;
        logic               burst;
        logic [rad_pkg::CountW-1:0] len;

        start       = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        mismatches  = 0;
        words_sent  = 0;
        none        = '0;
        for (int k = 0; k <= MaxDev; k++)
        begin
            prior_totals[k] = '0;
            row_totals[k]   = '0;
            row_profits[k]  = '0;
        end
        next_count  = 5'd1;
        row_len_reg = rad_pkg::NumDevReset;

        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        foreach (DirPlan[n])
        begin
            if (DirPlan[n].kind == SET_LEN)
                set_row_length(DirPlan[n].len);
            else
            begin
                push_word(DirPlan[n].word, DirPlan[n].typed, DirPlan[n].res);
                hold_off($urandom_range(0, 1));
            end
        end

        // Random phases: a row length, then rows with random content; a phase may
        // stop mid-row so the next length write lands inside a row
        phase = 0;
        while (words_sent < NumWords + DirSteps)
        begin
            if (phase < 10)
                len = LenSweep[phase];
            else if ($urandom_range(0, 9) < 7)
                len = 5'($urandom_range(1, 6));
            else
                len = 5'($urandom_range(0, 31));
            set_row_length(len);
            phase_words = $urandom_range(15, 90);
            burst       = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_words; n++)
            begin
                w.profit = pick_profit();
                if (next_count == 1)
                    w.new_problem = ($urandom_range(0, 4) == 0);
                else
                    w.new_problem = ($urandom_range(0, 29) == 0);
                push_word(w, 1'b0, none);
                if (!burst)
                    hold_off(gap_len());
            end
            phase++;
        end

        // Drain
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (2 * MaxDev + 8)
            @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("resource_allocation_dp_core regression: pass");
        else
            $display("resource_allocation_dp_core regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("resource_allocation_dp_core regression: fail");
        $finish;
    end

endmodule

### files.f
design/rad_pkg.sv
design/rad_ctrl.sv
design/rad_datapath.sv
design/resource_allocation_dp_core.sv
design/rad_checker.sv
sim/tb_top.sv
